[rtl/firmware_page_upload_sender_unit_defines.svh]
// Assertion macros shared by the firmware page upload sender RTL.
`ifndef FIRMWARE_PAGE_UPLOAD_SENDER_UNIT_DEFINES_SVH
`define FIRMWARE_PAGE_UPLOAD_SENDER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPUS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpus assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FPUS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpus assertion failed");

`endif

[rtl/fpus_pkg.sv]
// Package with the codes, constants and types of the firmware page upload sender.
`timescale 1ns / 1ps
package fpus_pkg;

   localparam logic [2:0] CMD_START    = 3'd0;
   localparam logic [2:0] CMD_SLOT     = 3'd1;
   localparam logic [2:0] CMD_RESPONSE = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_ABORT    = 3'd4;

   localparam logic [2:0] PH_READY    = 3'd0;
   localparam logic [2:0] PH_WAITING  = 3'd1;
   localparam logic [2:0] PH_SENDING  = 3'd2;
   localparam logic [2:0] PH_SUCCESS  = 3'd3;
   localparam logic [2:0] PH_ERROR    = 3'd4;
   localparam logic [2:0] PH_INVALID  = 3'd5;
   localparam logic [2:0] PH_TO_START = 3'd6;
   localparam logic [2:0] PH_TO_SEND  = 3'd7;

   localparam logic [7:0] REQUEST_CODE = 8'hff;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam logic [1:0] REG_LOCAL_NODE_ID   = 2'd0;
   localparam logic [1:0] REG_STARTUP_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SENDING_TIMEOUT = 2'd2;

   localparam logic [15:0] STARTUP_TIMEOUT_RESET = 16'd6000;
   localparam logic [15:0] SENDING_TIMEOUT_RESET = 16'd4500;

   typedef struct packed {
      logic [7:0]  local_node_id;
      logic [15:0] startup_timeout_ms;
      logic [15:0] sending_timeout_ms;
   } cfg_type;

endpackage

[rtl/fpus_req_if.sv]
// Input channel of the firmware page upload sender.
`timescale 1ns / 1ps
interface fpus_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  peer_node;
   logic [31:0] page_total;
   logic [31:0] page_number;
   logic        page_available;
   logic [31:0] data_word;
   logic        transmit_ready;

   modport source (
      output valid, cmd, peer_node, page_total, page_number, page_available,
             data_word, transmit_ready,
      input  ready
   );
   modport sink (
      input  valid, cmd, peer_node, page_total, page_number, page_available,
             data_word, transmit_ready,
      output ready
   );
endinterface

[rtl/fpus_rsp_if.sv]
// Result channel of the firmware page upload sender.
`timescale 1ns / 1ps
interface fpus_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        tx_valid;
   logic [7:0]  tx_dest;
   logic [7:0]  tx_code;
   logic [31:0] tx_data;
   logic [2:0]  phase_code;
   logic [7:0]  word_index_out;

   modport source (
      output valid, accepted, tx_valid, tx_dest, tx_code, tx_data, phase_code,
             word_index_out,
      input  ready
   );
   modport sink (
      input  valid, accepted, tx_valid, tx_dest, tx_code, tx_data, phase_code,
             word_index_out,
      output ready
   );
endinterface

[rtl/fpus_csr.sv]
// APB-style configuration registers of the firmware page upload sender.
`timescale 1ns / 1ps
module fpus_csr
   import fpus_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_LOCAL_NODE_ID:   cfg_in.local_node_id      = csr_pwdata[7:0];
            REG_STARTUP_TIMEOUT: cfg_in.startup_timeout_ms = csr_pwdata[15:0];
            REG_SENDING_TIMEOUT: cfg_in.sending_timeout_ms = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LOCAL_NODE_ID:   csr_prdata = {24'd0, cfg_ff.local_node_id};
         REG_STARTUP_TIMEOUT: csr_prdata = {16'd0, cfg_ff.startup_timeout_ms};
         REG_SENDING_TIMEOUT: csr_prdata = {16'd0, cfg_ff.sending_timeout_ms};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_node_id      <= 8'd0;
         cfg_ff.startup_timeout_ms <= STARTUP_TIMEOUT_RESET;
         cfg_ff.sending_timeout_ms <= SENDING_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/firmware_page_upload_sender_unit.sv]
// Top level of the firmware page upload sender.
//
// The req channel carries one command item: start, send slot, peer response,
// millisecond tick or abort. Each accepted item yields exactly one result item
// on the rsp channel, with the message to emit (if any), the phase after the
// item and the word count of the current page.
// Configuration registers are to be written by the user over the APB-style csr
// port only while the block is idle; the block does not enforce this. pready is
// always high and a write takes setup and access. The result of an item is
// registered and valid after the edge that accepts the item. Throughput is one
// item per cycle unless the receiver stalls, set by the single result register
// that follows the next-state logic. When the receiver stalls, the result
// register holds its item and req.ready stays low until it is taken; an item is
// accepted in the same cycle in which the waiting result leaves.
// Reset puts the phase at ready, clears all upload state and loads the
// register defaults: node 0, startup timeout 6000 and sending timeout 4500.
// The abort command clears the upload state but keeps the registers.
`timescale 1ns / 1ps
`include "firmware_page_upload_sender_unit_defines.svh"
module firmware_page_upload_sender_unit
   import fpus_pkg::*;
#(
   parameter int unsigned WORDS_PER_PAGE = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   fpus_req_if.sink                  req,
   fpus_rsp_if.source                rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam logic [7:0] WordsLast = WORDS_PER_PAGE[7:0];

   cfg_type     cfg;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  peer_ff, peer_in;
   logic [31:0] pages_total_ff, pages_total_in;
   logic [31:0] page_current_ff, page_current_in;
   logic [7:0]  word_index_ff, word_index_in;
   logic [15:0] timer_left_ff, timer_left_in;

   logic        rsp_valid_ff;
   logic        accepted_ff, accepted_in;
   logic        tx_valid_ff, tx_valid_in;
   logic [7:0]  tx_dest_ff, tx_dest_in;
   logic [7:0]  tx_code_ff, tx_code_in;
   logic [31:0] tx_data_ff, tx_data_in;

   logic        take;
   logic        active;
   logic [7:0]  word_next;
   logic [31:0] page_next;

   fpus_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign active    = (phase_ff == PH_WAITING) || (phase_ff == PH_SENDING);
   assign word_next = word_index_ff + 8'd1;
   assign page_next = page_current_ff + 32'd1;

   always_comb begin
      phase_in        = phase_ff;
      peer_in         = peer_ff;
      pages_total_in  = pages_total_ff;
      page_current_in = page_current_ff;
      word_index_in   = word_index_ff;
      timer_left_in   = timer_left_ff;
      accepted_in     = 1'b0;
      tx_valid_in     = 1'b0;
      tx_dest_in      = 8'd0;
      tx_code_in      = 8'd0;
      tx_data_in      = 32'd0;
      case (req.cmd)
         CMD_START: begin
            if (phase_ff == PH_READY) begin
               peer_in         = 8'd0;
               pages_total_in  = 32'd0;
               page_current_in = 32'd0;
               word_index_in   = 8'd0;
               timer_left_in   = 16'd0;
               if ((req.page_total != 32'd0) && req.transmit_ready) begin
                  tx_valid_in    = 1'b1;
                  tx_dest_in     = req.peer_node;
                  tx_code_in     = REQUEST_CODE;
                  tx_data_in     = req.page_total;
                  phase_in       = PH_WAITING;
                  peer_in        = req.peer_node;
                  pages_total_in = req.page_total;
                  timer_left_in  = cfg.startup_timeout_ms;
                  accepted_in    = 1'b1;
               end
            end
         end
         CMD_SLOT: begin
            if (active) begin
               if ((phase_ff == PH_SENDING) && req.transmit_ready) begin
                  tx_valid_in   = 1'b1;
                  tx_dest_in    = peer_ff;
                  tx_code_in    = word_index_ff;
                  tx_data_in    = req.data_word;
                  accepted_in   = 1'b1;
                  word_index_in = word_next;
                  if (word_next == WordsLast) begin
                     page_current_in = page_next;
                     if (page_next < pages_total_ff) begin
                        phase_in = PH_WAITING;
                     end else begin
                        timer_left_in = 16'd0;
                        phase_in      = PH_SUCCESS;
                     end
                  end
               end
            end else if (phase_ff != PH_READY) begin
               phase_in = PH_ERROR;
            end
         end
         CMD_RESPONSE: begin
            if ((phase_ff == PH_WAITING) && (req.peer_node == peer_ff)) begin
               page_current_in = req.page_number;
               if (!req.page_available) begin
                  phase_in      = PH_INVALID;
                  timer_left_in = 16'd0;
               end else begin
                  word_index_in = 8'd0;
                  phase_in      = PH_SENDING;
                  timer_left_in = cfg.sending_timeout_ms;
               end
            end
         end
         CMD_TICK: begin
            if (timer_left_ff != 16'd0) begin
               timer_left_in = timer_left_ff - 16'd1;
               if ((timer_left_ff == 16'd1) && active) begin
                  if ((page_current_ff == 32'd0) && (word_index_ff == 8'd0)) begin
                     phase_in = PH_TO_START;
                  end else begin
                     phase_in = PH_TO_SEND;
                  end
               end
            end
         end
         CMD_ABORT: begin
            phase_in        = PH_READY;
            peer_in         = 8'd0;
            pages_total_in  = 32'd0;
            page_current_in = 32'd0;
            word_index_in   = 8'd0;
            timer_left_in   = 16'd0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_READY;
         peer_ff         <= 8'd0;
         pages_total_ff  <= 32'd0;
         page_current_ff <= 32'd0;
         word_index_ff   <= 8'd0;
         timer_left_ff   <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (take) begin
            phase_ff        <= phase_in;
            peer_ff         <= peer_in;
            pages_total_ff  <= pages_total_in;
            page_current_ff <= page_current_in;
            word_index_ff   <= word_index_in;
            timer_left_ff   <= timer_left_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff <= accepted_in;
         tx_valid_ff <= tx_valid_in;
         tx_dest_ff  <= tx_dest_in;
         tx_code_ff  <= tx_code_in;
         tx_data_ff  <= tx_data_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = accepted_ff;
   assign rsp.tx_valid       = tx_valid_ff;
   assign rsp.tx_dest        = tx_dest_ff;
   assign rsp.tx_code        = tx_code_ff;
   assign rsp.tx_data        = tx_data_ff;
   assign rsp.phase_code     = phase_ff;
   assign rsp.word_index_out = word_index_ff;

   `FPUS_ASSERT_NEXT(a_take_gives_result, take, rsp_valid_ff)
   `FPUS_ASSERT_NOW(a_quiet_payload_zero, rsp_valid_ff && !tx_valid_ff,
      (tx_dest_ff == 8'd0) && (tx_code_ff == 8'd0) && (tx_data_ff == 32'd0))
   `FPUS_ASSERT_NOW(a_message_accepted, rsp_valid_ff && tx_valid_ff, accepted_ff)
   `FPUS_ASSERT_NOW(a_idle_timer_off, !active, timer_left_ff == 16'd0)
   `FPUS_ASSERT_NOW(a_sending_index_in_page, phase_ff == PH_SENDING,
      word_index_ff < WordsLast)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the firmware page upload sender: directed items, then random uploads.
`timescale 1ns / 1ps
module tb_top;
   import fpus_pkg::*;

   localparam int PAGE_WORDS = 128;
   localparam logic [2:0] CMD_SPARE = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned MAX_REPORTS = 100;
   localparam int unsigned LONG_HOLD = 60;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  peer_node;
      logic [31:0] page_total;
      logic [31:0] page_number;
      logic        page_available;
      logic [31:0] data_word;
      logic        transmit_ready;
   } upload_item_type;

   typedef struct packed {
      logic        accepted;
      logic        tx_valid;
      logic [7:0]  tx_dest;
      logic [7:0]  tx_code;
      logic [31:0] tx_data;
      logic [2:0]  phase_code;
      logic [7:0]  word_index_out;
   } upload_result_type;

   typedef struct packed {
      upload_item_type   item;
      logic              fixed;
      upload_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   fpus_req_if req();
   fpus_rsp_if rsp();

   firmware_page_upload_sender_unit #(.WORDS_PER_PAGE(PAGE_WORDS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   cfg_type upload_cfg = '{8'h00, STARTUP_TIMEOUT_RESET, SENDING_TIMEOUT_RESET};
   logic [2:0]  trk_phase = PH_READY;
   logic [7:0]  trk_peer = 8'h00;
   logic [31:0] trk_pages = 32'h0;
   logic [31:0] trk_page = 32'h0;
   logic [7:0]  trk_words = 8'h00;
   logic [15:0] trk_timer = 16'h0;

   upload_result_type results_due[$];
   logic              offered_fixed = 1'b0;
   upload_result_type offered_want = '0;
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;
   int unsigned       items_offered = 0;
   int unsigned       hold_request = 0;
   int unsigned       tick_pct = 3;
   bit                back_to_back = 1'b0;

   function automatic void clear_tracker();
      trk_phase = PH_READY;
      trk_peer = 8'h00;
      trk_pages = 32'h0;
      trk_page = 32'h0;
      trk_words = 8'h00;
      trk_timer = 16'h0;
   endfunction

   function automatic upload_result_type advance_upload(input upload_item_type it);
      upload_result_type r;
      logic busy;
      r = '0;
      busy = (trk_phase == PH_WAITING) || (trk_phase == PH_SENDING);
      case (it.cmd)
         CMD_START: begin
            if (trk_phase == PH_READY) begin
               clear_tracker();
               if (it.page_total != 32'h0 && it.transmit_ready) begin
                  r.accepted = 1'b1;
                  r.tx_valid = 1'b1;
                  r.tx_dest = it.peer_node;
                  r.tx_code = REQUEST_CODE;
                  r.tx_data = it.page_total;
                  trk_phase = PH_WAITING;
                  trk_peer = it.peer_node;
                  trk_pages = it.page_total;
                  trk_timer = upload_cfg.startup_timeout_ms;
               end
            end
         end
         CMD_SLOT: begin
            if (busy) begin
               if (trk_phase == PH_SENDING && it.transmit_ready) begin
                  r.accepted = 1'b1;
                  r.tx_valid = 1'b1;
                  r.tx_dest = trk_peer;
                  r.tx_code = trk_words;
                  r.tx_data = it.data_word;
                  trk_words = trk_words + 8'd1;
                  if (trk_words == 8'(PAGE_WORDS)) begin
                     trk_page = trk_page + 32'd1;
                     if (trk_page < trk_pages) begin
                        trk_phase = PH_WAITING;
                     end else begin
                        trk_timer = 16'h0;
                        trk_phase = PH_SUCCESS;
                     end
                  end
               end
            end else if (trk_phase != PH_READY) begin
               trk_phase = PH_ERROR;
            end
         end
         CMD_RESPONSE: begin
            if (trk_phase == PH_WAITING && it.peer_node == trk_peer) begin
               trk_page = it.page_number;
               if (!it.page_available) begin
                  trk_phase = PH_INVALID;
                  trk_timer = 16'h0;
               end else begin
                  trk_words = 8'h00;
                  trk_phase = PH_SENDING;
                  trk_timer = upload_cfg.sending_timeout_ms;
               end
            end
         end
         CMD_TICK: begin
            if (trk_timer != 16'h0) begin
               trk_timer = trk_timer - 16'd1;
               if (trk_timer == 16'h0 && busy) begin
                  trk_phase = (trk_page == 32'h0 && trk_words == 8'h00) ? PH_TO_START
                                                                       : PH_TO_SEND;
               end
            end
         end
         CMD_ABORT: clear_tracker();
         default: ;
      endcase
      r.phase_code = trk_phase;
      r.word_index_out = trk_words;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS) begin
         $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
                  field, cycle_count, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      upload_item_type   seen;
      upload_result_type got;
      upload_result_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.accepted, rsp.tx_valid, rsp.tx_dest, rsp.tx_code, rsp.tx_data,
                    rsp.phase_code, rsp.word_index_out};
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result item", 32'h1, 32'h0);
            end else begin
               want = results_due.pop_front();
               if (got.accepted !== want.accepted)
                  report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
               if (got.tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
               if (got.tx_dest !== want.tx_dest)
                  report_mismatch("tx_dest", 32'(got.tx_dest), 32'(want.tx_dest));
               if (got.tx_code !== want.tx_code)
                  report_mismatch("tx_code", 32'(got.tx_code), 32'(want.tx_code));
               if (got.tx_data !== want.tx_data)
                  report_mismatch("tx_data", got.tx_data, want.tx_data);
               if (got.phase_code !== want.phase_code)
                  report_mismatch("phase_code", 32'(got.phase_code),
                                  32'(want.phase_code));
               if (got.word_index_out !== want.word_index_out)
                  report_mismatch("word_index_out", 32'(got.word_index_out),
                                  32'(want.word_index_out));
            end
         end
         if (req.valid && req.ready) begin
            seen = '{req.cmd, req.peer_node, req.page_total, req.page_number,
                     req.page_available, req.data_word, req.transmit_ready};
            want = advance_upload(seen);
            if (offered_fixed) begin
               want = offered_want;
            end
            results_due.push_back(want);
         end
      end
   end

   initial begin : result_sink
      int unsigned hold;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            hold = hold_request;
            hold_request = 0;
         end else begin
            hold = back_to_back ? 0 : $urandom_range(0, 5);
         end
         if (hold != 0) begin
            rsp.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   task automatic offer_item(input upload_item_type it, input logic fixed,
                             input upload_result_type want);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.cmd <= it.cmd;
      req.peer_node <= it.peer_node;
      req.page_total <= it.page_total;
      req.page_number <= it.page_number;
      req.page_available <= it.page_available;
      req.data_word <= it.data_word;
      req.transmit_ready <= it.transmit_ready;
      offered_fixed <= fixed;
      offered_want <= want;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      items_offered++;
   endtask

   task automatic settle_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic write, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(input logic [1:0] idx);
      logic [31:0] rd;
      logic [31:0] want;
      case (idx)
         REG_LOCAL_NODE_ID:   want = {24'h0, upload_cfg.local_node_id};
         REG_STARTUP_TIMEOUT: want = {16'h0, upload_cfg.startup_timeout_ms};
         default:             want = {16'h0, upload_cfg.sending_timeout_ms};
      endcase
      csr_cycle(1'b0, idx, 32'h0, rd);
      if (rd !== want) report_mismatch("register read", rd, want);
   endtask

   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_cycle(1'b1, idx, value, rd);
      case (idx)
         REG_LOCAL_NODE_ID:   upload_cfg.local_node_id = value[7:0];
         REG_STARTUP_TIMEOUT: upload_cfg.startup_timeout_ms = value[15:0];
         default:             upload_cfg.sending_timeout_ms = value[15:0];
      endcase
      read_register(idx);
   endtask

   function automatic upload_item_type random_item();
      upload_item_type it;
      it.cmd = 3'($urandom_range(0, 7));
      it.peer_node = 8'($urandom);
      it.page_total = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
      it.page_number = $urandom;
      it.page_available = 1'($urandom);
      it.data_word = $urandom;
      it.transmit_ready = 1'($urandom);
      return it;
   endfunction

   function automatic upload_result_type quiet(input logic [2:0] ph,
                                               input logic [7:0] words);
      upload_result_type r;
      r = '0;
      r.phase_code = ph;
      r.word_index_out = words;
      return r;
   endfunction

   function automatic upload_result_type sent(input logic [7:0] dest,
                                              input logic [7:0] code,
                                              input logic [31:0] data, input logic [2:0] ph,
                                              input logic [7:0] words);
      upload_result_type r;
      r = '{1'b1, 1'b1, dest, code, data, ph, words};
      return r;
   endfunction

   function automatic directed_row_type row(input logic [2:0] c, input logic [7:0] node,
                                            input logic [31:0] total,
                                            input logic [31:0] pnum,
                                            input logic avail, input logic [31:0] word,
                                            input logic txr, input logic fixed,
                                            input upload_result_type want);
      directed_row_type d;
      d.item = '{c, node, total, pnum, avail, word, txr};
      d.fixed = fixed;
      d.want = want;
      return d;
   endfunction

   task automatic offer_random(input logic [2:0] c);
      upload_item_type it;
      it = random_item();
      it.cmd = c;
      offer_item(it, 1'b0, '0);
   endtask

   // One upload attempt: a start, then per page a request answer and its data words,
   // with ticks, stalled slots and aborts mixed in.
   task automatic run_upload_session(input int unsigned budget_end);
      upload_item_type it;
      logic [7:0]  peer;
      logic [31:0] pages;
      int unsigned page;
      int unsigned words;
      int unsigned pick;
      bit stop;
      stop = 1'b0;
      if ($urandom_range(0, 4) != 0) offer_random(CMD_ABORT);
      peer = 8'($urandom);
      pages = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 2);
      it = random_item();
      it.cmd = CMD_START;
      it.peer_node = peer;
      it.page_total = pages;
      it.transmit_ready = ($urandom_range(0, 9) != 0);
      offer_item(it, 1'b0, '0);
      page = 0;
      while (!stop && page < 3 && page < pages && items_offered < budget_end) begin
         repeat ($urandom_range(0, 2)) offer_random(CMD_TICK);
         it = random_item();
         it.cmd = CMD_RESPONSE;
         it.peer_node = ($urandom_range(0, 9) == 0) ? 8'($urandom) : peer;
         it.page_number = ($urandom_range(0, 3) == 0) ? $urandom : page;
         it.page_available = ($urandom_range(0, 19) != 0);
         offer_item(it, 1'b0, '0);
         if (!it.page_available) stop = 1'b1;
         words = 0;
         while (!stop && words < PAGE_WORDS && items_offered < budget_end) begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
               offer_random(CMD_TICK);
            end else if (pick == tick_pct) begin
               offer_random(CMD_ABORT);
               stop = 1'b1;
            end else begin
               it = random_item();
               it.cmd = CMD_SLOT;
               it.transmit_ready = (pick >= tick_pct + 5);
               offer_item(it, 1'b0, '0);
               if (it.transmit_ready) words++;
            end
         end
         page++;
      end
      repeat ($urandom_range(0, 3)) offer_item(random_item(), 1'b0, '0);
   endtask

   initial begin : stimulus
      directed_row_type plan[$];
      int unsigned budget;
      int unsigned sessions;
      req.valid <= 1'b0;
      req.cmd <= CMD_ABORT;
      req.peer_node <= 8'h00;
      req.page_total <= 32'h0;
      req.page_number <= 32'h0;
      req.page_available <= 1'b0;
      req.data_word <= 32'h0;
      req.transmit_ready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= 32'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_register(REG_LOCAL_NODE_ID);
      read_register(REG_STARTUP_TIMEOUT);
      read_register(REG_SENDING_TIMEOUT);
      set_register(REG_LOCAL_NODE_ID, 32'h0000_00a5);
      set_register(REG_STARTUP_TIMEOUT, 32'd2);
      set_register(REG_SENDING_TIMEOUT, 32'd2);

      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_RESPONSE, 8'h00, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_START, 8'h33, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_START, 8'h33, 32'd5, 32'h0, 1'b1, 32'h0, 1'b0,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_START, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
                         32'hffff_ffff, 1'b1, 1'b1,
                         sent(8'hff, REQUEST_CODE, 32'hffff_ffff, PH_WAITING, 8'd0)));
      plan.push_back(row(CMD_START, 8'h12, 32'd9, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_WAITING, 8'd0)));
      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h1234, 1'b1,
                         1'b1, quiet(PH_WAITING, 8'd0)));
      plan.push_back(row(CMD_RESPONSE, 8'h00, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_WAITING, 8'd0)));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_WAITING, 8'd0)));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_TO_START, 8'd0)));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_TO_START, 8'd0)));
      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
                         1'b1, quiet(PH_ERROR, 8'd0)));
      plan.push_back(row(CMD_START, 8'h44, 32'd1, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_ERROR, 8'd0)));
      plan.push_back(row(CMD_ABORT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_START, 8'h5a, 32'd3, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, '0));
      plan.push_back(row(CMD_RESPONSE, 8'h5a, 32'h0, 32'hffff_ffff, 1'b1, 32'h0, 1'b1,
                         1'b0, '0));
      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'hffff_ffff, 1'b1, 1'b1,
                         sent(8'h5a, 8'h00, 32'hffff_ffff, PH_SENDING, 8'd1)));
      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h5555_aaaa, 1'b0,
                         1'b0, '0));
      plan.push_back(row(CMD_SLOT, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1, 1'b0, '0));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1, 1'b0, '0));
      plan.push_back(row(CMD_TICK, 8'h00, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_TO_SEND, 8'd2)));
      plan.push_back(row(CMD_ABORT, 8'hff, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1,
                         1'b1, quiet(PH_READY, 8'd0)));
      plan.push_back(row(CMD_START, 8'h5a, 32'd1, 32'h0, 1'b1, 32'h0, 1'b1, 1'b0, '0));
      plan.push_back(row(CMD_RESPONSE, 8'h5a, 32'h0, 32'd7, 1'b0, 32'h0, 1'b1,
                         1'b1, quiet(PH_INVALID, 8'd0)));
      plan.push_back(row(CMD_SPARE, 8'h5a, 32'd1, 32'd1, 1'b1, 32'h1, 1'b1, 1'b0, '0));
      foreach (plan[i]) offer_item(plan[i].item, plan[i].fixed, plan[i].want);
      settle_results();

      // Each round runs under its own register setting: largest timeouts, timers off,
      // then short timeouts with frequent ticks so that both timeouts fire.
      for (int round = 0; round < 3; round++) begin
         case (round)
            0: begin
               set_register(REG_LOCAL_NODE_ID, 32'h0000_00ff);
               set_register(REG_STARTUP_TIMEOUT, 32'h0000_ffff);
               set_register(REG_SENDING_TIMEOUT, 32'h0000_ffff);
               tick_pct = 3;
               hold_request = LONG_HOLD;
            end
            1: begin
               set_register(REG_LOCAL_NODE_ID, 32'h0);
               set_register(REG_STARTUP_TIMEOUT, 32'h0);
               set_register(REG_SENDING_TIMEOUT, 32'h0);
               tick_pct = 3;
            end
            default: begin
               set_register(REG_LOCAL_NODE_ID, 32'($urandom_range(1, 254)));
               set_register(REG_STARTUP_TIMEOUT, 32'($urandom_range(1, 4)));
               set_register(REG_SENDING_TIMEOUT, 32'($urandom_range(8, 30)));
               tick_pct = 15;
            end
         endcase
         budget = items_offered + ((round == 2) ? 120 : 170);
         sessions = 0;
         while (items_offered < budget) begin
            back_to_back = (round == 1 && sessions == 0);
            run_upload_session(budget);
            back_to_back = 1'b0;
            if (round == 0 && sessions == 0) settle_results();
            sessions++;
         end
         settle_results();
      end

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
